// ===== rtl/core/qtn_pkg.sv =====
// ============================================================================
// qtn_pkg
// Shared constants, command codes, status type and stop-word table of the
// query text normalizer.
// ============================================================================
package qtn_pkg;

  localparam int TERM_BUFFER_BYTES = 8;
  localparam int STOP_WORD_COUNT   = 47;
  localparam int ROM_WORDS         = 47;
  localparam int STOP_MAX_LEN      = 6;
  localparam int HOLD_LIMIT = (TERM_BUFFER_BYTES < STOP_MAX_LEN) ? TERM_BUFFER_BYTES
                                                                 : STOP_MAX_LEN;
  localparam int LEN_W  = $clog2(HOLD_LIMIT + 1);
  localparam int IDX_W  = (HOLD_LIMIT > 1) ? $clog2(HOLD_LIMIT) : 1;
  localparam int WORDS  = (STOP_WORD_COUNT < ROM_WORDS) ? STOP_WORD_COUNT : ROM_WORDS;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_ALNUM = 3'd2;
  localparam logic [2:0] CMD_TERM  = 3'd3;
  localparam logic [2:0] CMD_FINAL = 3'd4;
  localparam logic [2:0] CMD_EMIT  = 3'd5;
  localparam logic [2:0] CMD_FLUSH = 3'd6;

  localparam logic [7:0] CH_LEAD  = 8'hEF;
  localparam logic [7:0] CH_PAGE0 = 8'hBC;
  localparam logic [7:0] CH_PAGE1 = 8'hBD;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic emit_busy;
    logic can_emit;
    logic out_free;
    logic term_more;
    logic alist_more;
    logic last;
  } qtn_sts_t;

  localparam logic [2:0] STOP_LEN [ROM_WORDS] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd6, 3'd3, 3'd3, 3'd6, 3'd3, 3'd3, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd3, 3'd1, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4,
    3'd4, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3
  };

  localparam logic [47:0] STOP_TXT [ROM_WORDS] = '{
    48'hE79A84_000000, 48'hE4BA86_000000, 48'hE59CA8_000000, 48'hE698AF_000000,
    48'hE68891_000000, 48'hE69C89_000000, 48'hE5928C_000000, 48'hE5B0B1_000000,
    48'hE4B88D_000000, 48'hE4BABA_000000, 48'hE983BD_000000, 48'hE4B880_000000,
    48'hE4B880_E4B8AA, 48'hE4B88A_000000, 48'hE4B99F_000000, 48'hE5BE88_000000,
    48'hE588B0_000000, 48'hE8AFB4_000000, 48'hE8A681_000000, 48'hE58EBB_000000,
    48'hE4BDA0_000000, 48'hE4BC9A_000000, 48'hE79D80_000000, 48'hE6B2A1_E69C89,
    48'hE79C8B_000000, 48'hE5A5BD_000000, 48'hE887AA_E5B7B1, 48'hE8BF99_000000,
    48'h746865_000000, 48'h697300_000000, 48'h617400_000000, 48'h6F6600_000000,
    48'h6F6E00_000000, 48'h616E64_000000, 48'h610000_000000, 48'h616E00_000000,
    48'h697400_000000, 48'h746F00_000000, 48'h746861_740000, 48'h746869_730000,
    48'h776974_680000, 48'h666F72_000000, 48'h617300_000000, 48'h776173_000000,
    48'h627574_000000, 48'h626500_000000, 48'h617265_000000
  };

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic is_stop(input logic [HOLD_LIMIT*8-1:0] txt,
                                   input logic [LEN_W-1:0] len);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int i = 0; i < WORDS; i++) begin
      eq = (32'(len) == 32'(STOP_LEN[i]));
      for (int k = 0; k < HOLD_LIMIT && k < STOP_MAX_LEN; k++) begin
        if (k < 32'(len) && txt[8*k +: 8] != STOP_TXT[i][47-8*k -: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        hit = 1'b1;
      end
    end
    is_stop = hit;
  endfunction

endpackage

// ===== rtl/core/qtn_ifs.sv =====
// ============================================================================
// qtn_ifs
// Valid/ready channels of the query text normalizer, one word per handshake.
// ============================================================================
interface qtn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface qtn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input out_last,
                output ready);
endinterface

// ===== rtl/core/qtn_ctrl.sv =====
// ============================================================================
// qtn_ctrl
// Sequencer that steps one input word through the datapath stages.
// ============================================================================
module qtn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qtn_pkg::qtn_sts_t sts,
  output logic [2:0]        cmd
);
  import qtn_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          fin_nxt   = 1'b0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.emit_busy) begin
          if (sts.can_emit) begin
            cmd = CMD_EMIT;
          end
        end else if (sts.term_more) begin
          cmd = CMD_TERM;
        end else if (sts.alist_more) begin
          cmd = CMD_ALNUM;
        end else if (sts.last && !fin_r) begin
          cmd     = CMD_FINAL;
          fin_nxt = 1'b1;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd       = CMD_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== rtl/core/qtn_dp.sv =====
// ============================================================================
// qtn_dp
// Datapath: fullwidth decode, class and space handling, repeat filter, term
// store with stop-word test, and the output staging and result registers.
// ============================================================================
module qtn_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        cmd,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              out_ready,
  output qtn_pkg::qtn_sts_t sts,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              out_last
);
  import qtn_pkg::*;

  logic [1:0]       wcnt_r, wcnt_nxt;
  logic [7:0]       wc1_r, wc1_nxt;
  logic [1:0]       pcls_r, pcls_nxt;
  logic             sp_r, sp_nxt;
  logic             cs_r, cs_nxt;
  logic [7:0]       h1_r, h1_nxt, h2_r, h2_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;
  logic [7:0]       store_r [HOLD_LIMIT];
  logic [7:0]       store_nxt [HOLD_LIMIT];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             eb_r, eb_nxt;
  logic [7:0]       abuf_r [3];
  logic [7:0]       abuf_nxt [3];
  logic [1:0]       acnt_r, acnt_nxt, aidx_r, aidx_nxt;
  logic             last_r, last_nxt;
  logic             tqs_r, tqs_nxt, tqv_r, tqv_nxt;
  logic [7:0]       tqc_r, tqc_nxt;
  logic             rel_r, rel_nxt, rclr_r, rclr_nxt;
  logic [LEN_W-1:0] ridx_r, ridx_nxt;
  logic             putv_r, putv_nxt;
  logic [7:0]       putb_r, putb_nxt;
  logic             stgv_r, stgv_nxt;
  logic [7:0]       stgb_r, stgb_nxt;
  logic             ov_r, ov_nxt, obv_r, obv_nxt, ol_r, ol_nxt;
  logic [7:0]       ob_r, ob_nxt;

  logic [HOLD_LIMIT*8-1:0] txt;
  logic                    stop_hit;
  logic                    out_free;
  logic [7:0]              a, lc, conv, eb_byte;
  logic [1:0]              cls;
  logic                    conv_ok, keep, drop, tsp;
  logic [LEN_W-1:0]        ridx_m1;

  always_comb begin
    for (int k = 0; k < HOLD_LIMIT; k++) begin
      txt[8*k +: 8] = store_r[k];
    end
  end

  assign stop_hit = is_stop(txt, len_r);
  assign out_free = !ov_r || out_ready;
  assign ridx_m1  = ridx_r - LEN_W'(1);

  assign sts.emit_busy  = rel_r || putv_r;
  assign sts.can_emit   = !stgv_r || out_free;
  assign sts.out_free   = out_free;
  assign sts.term_more  = tqs_r || tqv_r;
  assign sts.alist_more = (aidx_r != acnt_r);
  assign sts.last       = last_r;

  assign out_valid  = ov_r;
  assign out_byte   = ob_r;
  assign byte_valid = obv_r;
  assign out_last   = ol_r;

  always_comb begin
    conv_ok = 1'b0;
    conv    = in_byte;
    if (wc1_r == CH_PAGE0 && in_byte == 8'h80) begin
      conv_ok = 1'b1;
      conv    = CH_SPACE;
    end else if (wc1_r == CH_PAGE0 && ((in_byte >= 8'hA1 && in_byte <= 8'hBA) ||
                                       (in_byte >= 8'h90 && in_byte <= 8'h99))) begin
      conv_ok = 1'b1;
      conv    = in_byte - 8'h60;
    end else if (wc1_r == CH_PAGE1 && in_byte >= 8'h81 && in_byte <= 8'h9A) begin
      conv_ok = 1'b1;
      conv    = in_byte - 8'h20;
    end
  end

  always_comb begin
    wcnt_nxt = wcnt_r;  wc1_nxt = wc1_r;   pcls_nxt = pcls_r;
    sp_nxt   = sp_r;    cs_nxt  = cs_r;    h1_nxt   = h1_r;    h2_nxt = h2_r;
    hcnt_nxt = hcnt_r;  store_nxt = store_r; len_nxt = len_r;  ovf_nxt = ovf_r;
    eb_nxt   = eb_r;    abuf_nxt = abuf_r; acnt_nxt = acnt_r;  aidx_nxt = aidx_r;
    last_nxt = last_r;  tqs_nxt = tqs_r;   tqv_nxt = tqv_r;    tqc_nxt = tqc_r;
    rel_nxt  = rel_r;   rclr_nxt = rclr_r; ridx_nxt = ridx_r;
    putv_nxt = putv_r;  putb_nxt = putb_r; stgv_nxt = stgv_r;  stgb_nxt = stgb_r;
    ov_nxt   = ov_r && !out_ready;
    ob_nxt   = ob_r;    obv_nxt = obv_r;   ol_nxt = ol_r;
    a = abuf_r[aidx_r];
    cls = 2'd0; lc = a; keep = 1'b0; drop = 1'b0; tsp = 1'b0;
    eb_byte = CH_SPACE;

    unique case (cmd)
      CMD_LOAD: begin
        last_nxt = in_last;
        aidx_nxt = 2'd0;
        acnt_nxt = 2'd0;
        wcnt_nxt = 2'd0;
        abuf_nxt[0] = CH_LEAD;
        abuf_nxt[1] = in_byte;
        abuf_nxt[2] = CH_LEAD;
        case (wcnt_r)
          2'd0: begin
            if (in_byte == CH_LEAD) begin
              if (in_last) acnt_nxt = 2'd1;
              else wcnt_nxt = 2'd1;
            end else begin
              abuf_nxt[0] = in_byte;
              acnt_nxt    = 2'd1;
            end
          end
          2'd1: begin
            if (in_byte == CH_PAGE0 || in_byte == CH_PAGE1) begin
              if (in_last) begin
                acnt_nxt = 2'd2;
              end else begin
                wcnt_nxt = 2'd2;
                wc1_nxt  = in_byte;
              end
            end else if (in_byte == CH_LEAD) begin
              if (in_last) begin
                acnt_nxt = 2'd2;
              end else begin
                acnt_nxt = 2'd1;
                wcnt_nxt = 2'd1;
              end
            end else begin
              acnt_nxt = 2'd2;
            end
          end
          default: begin
            abuf_nxt[1] = wc1_r;
            if (conv_ok) begin
              abuf_nxt[0] = conv;
              acnt_nxt    = 2'd1;
            end else if (in_byte == CH_LEAD) begin
              if (in_last) begin
                acnt_nxt = 2'd3;
              end else begin
                acnt_nxt = 2'd2;
                wcnt_nxt = 2'd1;
              end
            end else begin
              abuf_nxt[2] = in_byte;
              acnt_nxt    = 2'd3;
            end
          end
        endcase
      end
      CMD_ALNUM: begin
        aidx_nxt = aidx_r + 2'd1;
        cls = is_alpha(a) ? 2'd1 : (is_digit(a) ? 2'd2 : 2'd0);
        pcls_nxt = cls;
        if (((pcls_r == 2'd1 && cls == 2'd2) || (pcls_r == 2'd2 && cls == 2'd1)) && cs_r) begin
          sp_nxt = 1'b1;
        end
        lc = (a >= 8'h41 && a <= 8'h5A) ? a + 8'h20 : a;
        tqc_nxt = lc;
        tqv_nxt = 1'b0;
        if (lc == CH_SPACE || lc == CH_TAB) begin
          if (cs_r) sp_nxt = 1'b1;
        end else begin
          tsp    = sp_nxt;
          sp_nxt = 1'b0;
          cs_nxt = 1'b1;
          if (tsp) begin
            h2_nxt = h1_nxt;
            h1_nxt = CH_SPACE;
            if (hcnt_nxt != 2'd2) hcnt_nxt = hcnt_nxt + 2'd1;
          end
          keep = is_alpha(lc) || is_digit(lc) || lc >= 8'h80 || lc == 8'h27 ||
                 lc == 8'h2D || lc == 8'h5F;
          if (keep) begin
            drop = hcnt_nxt == 2'd2 && is_alpha(lc) && lc == h1_nxt && h1_nxt == h2_nxt;
            h2_nxt = h1_nxt;
            h1_nxt = lc;
            if (hcnt_nxt != 2'd2) hcnt_nxt = hcnt_nxt + 2'd1;
            tqv_nxt = !drop;
          end
        end
        tqs_nxt = tsp;
      end
      CMD_TERM: begin
        if (tqs_r) begin
          tqs_nxt = 1'b0;
          if (!ovf_r && len_r != '0 && !stop_hit) begin
            rel_nxt  = 1'b1;
            rclr_nxt = 1'b1;
            ridx_nxt = eb_r ? LEN_W'(0) : LEN_W'(1);
          end else begin
            len_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end else begin
          tqv_nxt = 1'b0;
          if (ovf_r) begin
            putv_nxt = 1'b1;
            putb_nxt = tqc_r;
          end else if (32'(len_r) < HOLD_LIMIT) begin
            store_nxt[len_r[IDX_W-1:0]] = tqc_r;
            len_nxt = len_r + LEN_W'(1);
          end else begin
            rel_nxt  = 1'b1;
            rclr_nxt = 1'b0;
            ridx_nxt = eb_r ? LEN_W'(0) : LEN_W'(1);
            putv_nxt = 1'b1;
            putb_nxt = tqc_r;
            ovf_nxt  = 1'b1;
          end
        end
      end
      CMD_FINAL: begin
        tqs_nxt = 1'b1;
        sp_nxt  = 1'b0;
      end
      CMD_EMIT: begin
        if (rel_r) begin
          if (ridx_r != '0) eb_byte = store_r[ridx_m1[IDX_W-1:0]];
          if (ridx_r == len_r) begin
            rel_nxt = 1'b0;
            eb_nxt  = 1'b1;
            if (rclr_r) begin
              len_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end else begin
            ridx_nxt = ridx_r + LEN_W'(1);
          end
        end else begin
          eb_byte  = putb_r;
          putv_nxt = 1'b0;
        end
        if (stgv_r) begin
          ov_nxt  = 1'b1;
          ob_nxt  = stgb_r;
          obv_nxt = 1'b1;
          ol_nxt  = 1'b0;
        end
        stgv_nxt = 1'b1;
        stgb_nxt = eb_byte;
      end
      CMD_FLUSH: begin
        stgv_nxt = 1'b0;
        if (last_r || stgv_r) begin
          ov_nxt  = 1'b1;
          ob_nxt  = stgv_r ? stgb_r : 8'h00;
          obv_nxt = stgv_r;
          ol_nxt  = last_r;
        end
        if (last_r) begin
          wcnt_nxt = 2'd0; pcls_nxt = 2'd0; sp_nxt = 1'b0; cs_nxt = 1'b0;
          h1_nxt = 8'h00; h2_nxt = 8'h00; hcnt_nxt = 2'd0;
          len_nxt = '0; ovf_nxt = 1'b0; eb_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= 2'd0; pcls_r <= 2'd0; sp_r <= 1'b0; cs_r <= 1'b0;
      h1_r <= 8'h00; h2_r <= 8'h00; hcnt_r <= 2'd0;
      len_r <= '0; ovf_r <= 1'b0; eb_r <= 1'b0;
      acnt_r <= 2'd0; aidx_r <= 2'd0; last_r <= 1'b0;
      tqs_r <= 1'b0; tqv_r <= 1'b0; rel_r <= 1'b0; putv_r <= 1'b0;
      stgv_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      wcnt_r <= wcnt_nxt; pcls_r <= pcls_nxt; sp_r <= sp_nxt; cs_r <= cs_nxt;
      h1_r <= h1_nxt; h2_r <= h2_nxt; hcnt_r <= hcnt_nxt;
      len_r <= len_nxt; ovf_r <= ovf_nxt; eb_r <= eb_nxt;
      acnt_r <= acnt_nxt; aidx_r <= aidx_nxt; last_r <= last_nxt;
      tqs_r <= tqs_nxt; tqv_r <= tqv_nxt; rel_r <= rel_nxt; putv_r <= putv_nxt;
      stgv_r <= stgv_nxt; ov_r <= ov_nxt;
    end
    wc1_r <= wc1_nxt; store_r <= store_nxt; abuf_r <= abuf_nxt; tqc_r <= tqc_nxt;
    rclr_r <= rclr_nxt; ridx_r <= ridx_nxt; putb_r <= putb_nxt; stgb_r <= stgb_nxt;
    ob_r <= ob_nxt; obv_r <= obv_nxt; ol_r <= ol_nxt;
  end

endmodule

// ===== rtl/core/query_text_normalizer.sv =====
// ============================================================================
// query_text_normalizer
// Streaming normalizer for search query text, one byte word in per step.
// Each input word is loaded and decoded; its characters and term bytes are
// stepped through the filters and the term store, held term bytes are
// released through the staging register, and a flush moves staging into the
// result register. One word at a time: a new word is taken only when idle.
// Reset clears the query control state, counters and the result valid.
// ============================================================================
module query_text_normalizer (
  input logic      clk,
  input logic      rst_n,
  qtn_in_if.sink   in_ch,
  qtn_out_if.source out_ch
);
  import qtn_pkg::*;

  qtn_sts_t   sts;
  logic [2:0] cmd;

  qtn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qtn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_ch.in_byte),
    .in_last    (in_ch.in_last),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .out_last   (out_ch.out_last)
  );

endmodule

// ===== rtl/core/qtn_checker.sv =====
// ============================================================================
// qtn_checker
// Port-level checks of the query text normalizer.
// ============================================================================
module qtn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("Result word changed while stalled.");

  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> out_last)
    else $error("Empty result word without end of query.");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken while a word is in progress.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind query_text_normalizer qtn_checker u_qtn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .out_last   (out_ch.out_last)
);

// ===== tb/sv/qtn_scoreboard.sv =====
// ============================================================================
// qtn_scoreboard
// Predicts the normalized bytes of each query and checks the result words.
// ============================================================================
class qtn_scoreboard;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } norm_word_t;

  typedef logic [7:0] byte_t;

  localparam int HOLD = qtn_pkg::HOLD_LIMIT;

  norm_word_t   expected_words[$];
  int           mismatches;

  logic [7:0]   wide_lead;
  logic [1:0]   wide_count;
  logic [1:0]   prev_class;
  bit           space_due;
  bit           content_seen;
  logic [7:0]   hist1;
  logic [7:0]   hist2;
  int           hist_count;
  byte_t        term_bytes[HOLD];
  int           term_len;
  bit           term_spilled;
  bit           term_sent;
  norm_word_t   step_words[$];

  function new();
    mismatches = 0;
    clear_query();
  endfunction

  function void clear_query();
    wide_lead = 8'h00;
    wide_count = 2'd0;
    prev_class = 2'd0;
    space_due = 0;
    content_seen = 0;
    hist1 = 8'h00;
    hist2 = 8'h00;
    hist_count = 0;
    term_len = 0;
    term_spilled = 0;
    term_sent = 0;
  endfunction

  function bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function void put(logic [7:0] b);
    norm_word_t w;
    w.data = b;
    w.has_byte = 1'b1;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function bit held_is_stop_word();
    bit eq;
    for (int i = 0; i < qtn_pkg::WORDS; i++) begin
      eq = (term_len == int'(qtn_pkg::STOP_LEN[i]));
      for (int k = 0; k < term_len && eq; k++) begin
        if (term_bytes[k] != qtn_pkg::STOP_TXT[i][47-8*k -: 8]) eq = 0;
      end
      if (eq) return 1;
    end
    return 0;
  endfunction

  function void release_term();
    if (term_sent) put(" ");
    for (int k = 0; k < term_len; k++) put(term_bytes[k]);
    term_sent = 1;
  endfunction

  function void end_term();
    if (!term_spilled && term_len > 0 && !held_is_stop_word()) release_term();
    term_len = 0;
    term_spilled = 0;
  endfunction

  function void to_terms(logic [7:0] b);
    if (b == " ") begin
      end_term();
    end else if (term_spilled) begin
      put(b);
    end else if (term_len < HOLD) begin
      term_bytes[term_len] = b;
      term_len++;
    end else begin
      release_term();
      put(b);
      term_spilled = 1;
    end
  endfunction

  function void to_repeat(logic [7:0] b);
    bit drop;
    drop = hist_count >= 2 && letter(b) && b == hist1 && hist1 == hist2;
    hist2 = hist1;
    hist1 = b;
    if (hist_count < 2) hist_count++;
    if (!drop) to_terms(b);
  endfunction

  function void to_noise(logic [7:0] b);
    if (letter(b) || digit(b) || b >= 8'h80 || b == " " || b == "'" || b == "-" || b == "_")
      to_repeat(b);
  endfunction

  function void to_collapse(logic [7:0] b);
    if (b == " " || b == qtn_pkg::CH_TAB) begin
      if (content_seen) space_due = 1;
      return;
    end
    if (space_due) to_noise(" ");
    space_due = 0;
    content_seen = 1;
    to_noise(b);
  endfunction

  function void to_lower(logic [7:0] b);
    logic [1:0] cls;
    cls = letter(b) ? 2'd1 : (digit(b) ? 2'd2 : 2'd0);
    if ((prev_class == 2'd1 && cls == 2'd2) || (prev_class == 2'd2 && cls == 2'd1))
      to_collapse(" ");
    prev_class = cls;
    if (b >= "A" && b <= "Z") b = b + 8'd32;
    to_collapse(b);
  endfunction

  function void to_wide(logic [7:0] b);
    logic [7:0] page;
    if (wide_count == 2'd0) begin
      if (b == qtn_pkg::CH_LEAD) wide_count = 2'd1;
      else to_lower(b);
      return;
    end
    if (wide_count == 2'd1) begin
      if (b == qtn_pkg::CH_PAGE0 || b == qtn_pkg::CH_PAGE1) begin
        wide_lead = b;
        wide_count = 2'd2;
        return;
      end
      wide_count = 2'd0;
      to_lower(qtn_pkg::CH_LEAD);
      to_wide(b);
      return;
    end
    page = wide_lead;
    wide_count = 2'd0;
    if (page == qtn_pkg::CH_PAGE0 && b == 8'h80) to_lower(" ");
    else if (page == qtn_pkg::CH_PAGE0 && b >= 8'hA1 && b <= 8'hBA) to_lower(b - 8'hA1 + "A");
    else if (page == qtn_pkg::CH_PAGE0 && b >= 8'h90 && b <= 8'h99) to_lower(b - 8'h90 + "0");
    else if (page == qtn_pkg::CH_PAGE1 && b >= 8'h81 && b <= 8'h9A) to_lower(b - 8'h81 + "a");
    else begin
      to_lower(qtn_pkg::CH_LEAD);
      to_lower(page);
      to_wide(b);
    end
  endfunction

  function void note_input(logic [7:0] b, logic last);
    norm_word_t w;
    step_words.delete();
    to_wide(b);
    if (last) begin
      if (wide_count >= 2'd1) to_lower(qtn_pkg::CH_LEAD);
      if (wide_count == 2'd2) to_lower(wide_lead);
      wide_count = 2'd0;
      space_due = 0;
      end_term();
      if (step_words.size() == 0) begin
        w.data = 8'h00;
        w.has_byte = 1'b0;
        w.last = 1'b1;
        step_words.push_back(w);
      end else begin
        step_words[$].last = 1'b1;
      end
      clear_query();
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  function void check_result(logic [7:0] data, logic has_byte, logic last);
    norm_word_t w;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: byte %h valid %b last %b", data, has_byte, last);
      return;
    end
    w = expected_words.pop_front();
    if (w.data !== data || w.has_byte !== has_byte || w.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word differs: expected %h/%b/%b, got %h/%b/%b",
                 w.data, w.has_byte, w.last, data, has_byte, last);
    end
  endfunction

endclass

// ===== tb/sv/tb_query_text_normalizer.sv =====
// ============================================================================
// tb_query_text_normalizer
// Feeds directed and random query byte streams, with sender bursts and
// receiver stalls, and checks every result word against a predictor.
// ============================================================================
module tb_query_text_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  qtn_in_if  in_ch();
  qtn_out_if out_ch();

  query_text_normalizer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  qtn_scoreboard norm_model = new();
  int   idle_cycles = 0;
  int   stall_mode = 0;
  int   cycle_count = 0;
  int   gap_left = 0;
  int   items_sent = 0;
  logic [7:0] query_bytes[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 400 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= (cycle_count % 7) < 2;
    endcase
    if (rst_n && out_ch.valid && out_ch.ready)
      norm_model.check_result(out_ch.out_byte, out_ch.byte_valid, out_ch.out_last);
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("query_text_normalizer: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    if (gap_left == 0 && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap_left = $urandom_range(1, 20);
    end
    if (gap_left > 0) gap_left--;
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    norm_model.note_input(b, last);
    items_sent++;
  endtask

  task automatic send_query();
    for (int i = 0; i < query_bytes.size(); i++)
      send_word(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) query_bytes.push_back(s[i]);
  endtask

  task automatic add_random_piece();
    logic [7:0] b;
    int w;
    case ($urandom_range(0, 9))
      0: query_bytes.push_back(8'($urandom_range(0, 255)));
      1: begin
        query_bytes.push_back(qtn_pkg::CH_LEAD);
        query_bytes.push_back(qtn_pkg::CH_PAGE0);
        case ($urandom_range(0, 3))
          0: query_bytes.push_back(8'h80);
          1: query_bytes.push_back(8'($urandom_range(8'hA1, 8'hBA)));
          2: query_bytes.push_back(8'($urandom_range(8'h90, 8'h99)));
          default: query_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      2: begin
        query_bytes.push_back(qtn_pkg::CH_LEAD);
        query_bytes.push_back(qtn_pkg::CH_PAGE1);
        query_bytes.push_back($urandom_range(0, 3) != 0 ? 8'($urandom_range(8'h81, 8'h9A))
                                                        : 8'($urandom_range(0, 255)));
      end
      3: begin
        w = $urandom_range(0, qtn_pkg::WORDS - 1);
        for (int k = 0; k < qtn_pkg::STOP_LEN[w]; k++)
          query_bytes.push_back(qtn_pkg::STOP_TXT[w][47-8*k -: 8]);
      end
      4: query_bytes.push_back($urandom_range(0, 1) ? qtn_pkg::CH_SPACE : qtn_pkg::CH_TAB);
      5: repeat ($urandom_range(2, 4)) query_bytes.push_back(8'("a" + $urandom_range(0, 2)));
      6: query_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      7: query_bytes.push_back(8'("A" + $urandom_range(0, 25)));
      default: begin
        b = 8'("a" + $urandom_range(0, 25));
        query_bytes.push_back(b);
        if ($urandom_range(0, 1)) query_bytes.push_back(qtn_pkg::CH_SPACE);
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    query_bytes.delete(); add_text("  The QUICK  brown\tfox is 2day ok ");
    send_query();
    query_bytes.delete(); add_text("aaab coool extraordinary x-y_z'q !?#");
    send_query();
    query_bytes.delete();
    query_bytes = '{8'hEF, 8'hBC, 8'hA1, 8'hEF, 8'hBC, 8'h90, 8'hEF, 8'hBC, 8'h80,
                    8'hEF, 8'hBD, 8'h9A, 8'hEF, 8'h41, 8'hEF, 8'hBC, 8'h20, 8'hFF,
                    8'hE4, 8'hB8, 8'h80, 8'hEF, 8'hBD};
    send_query();
    query_bytes.delete(); query_bytes.push_back(8'h00); send_query();
    query_bytes.delete(); add_text("the"); send_query();

    while (items_sent < 470) begin
      query_bytes.delete();
      repeat ($urandom_range(1, 10)) add_random_piece();
      send_query();
    end
    in_ch.valid <= 1'b0;

    while (norm_model.expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (norm_model.mismatches == 0) begin
      $display("query_text_normalizer: match");
    end else begin
      $display("query_text_normalizer: mismatch");
    end
    $finish;
  end

endmodule
